/* rtl/avt_pkg.sv */
// Shared types, constants and helpers of the 2D affine vertex transform.
// No dependencies; every other file of the block imports this package.
package avt_pkg;

    localparam int AVT_FRAC_BITS = 16;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    typedef enum logic [2:0] {
        REG_ORIGIN  = 3'd0,
        REG_SHIFT   = 3'd1,
        REG_SCALE   = 3'd2,
        REG_ROT     = 3'd3,
        REG_SHEAR   = 3'd4,
        REG_REFLECT = 3'd5
    } avt_reg_e;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic               in_last;
    } avt_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               out_last;
    } avt_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } avt_vec_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] rot_cos;
        logic signed [31:0] rot_sin;
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic [1:0]         reflect;
    } avt_cfg_t;

    // Clamp a wide signed value into signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFFFFFF;
        end
        if (v < SAT_LO) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* rtl/avt_cfg.sv */
// Configuration register file of the affine vertex transform.
// Depends on avt_pkg for the register index codes and the config struct.
module avt_cfg
    import avt_pkg::*;
#(
    parameter int FRAC_BITS = AVT_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output avt_cfg_t    cfg
);

    localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

    logic [63:0] origin_reg, shift_reg, scale_reg, rot_reg, shear_reg;
    logic [63:0] origin_next, shift_next, scale_next, rot_next, shear_next;
    logic [1:0]  reflect_reg, reflect_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        origin_next  = origin_reg;
        shift_next   = shift_reg;
        scale_next   = scale_reg;
        rot_next     = rot_reg;
        shear_next   = shear_reg;
        reflect_next = reflect_reg;
        if (cfg_valid)
        begin
            unique case (avt_reg_e'(cfg_index))
                REG_ORIGIN:  origin_next  = cfg_data;
                REG_SHIFT:   shift_next   = cfg_data;
                REG_SCALE:   scale_next   = cfg_data;
                REG_ROT:     rot_next     = cfg_data;
                REG_SHEAR:   shear_next   = cfg_data;
                REG_REFLECT: reflect_next = cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg  <= '0;
            shift_reg   <= '0;
            scale_reg   <= {ONE_Q, ONE_Q};
            rot_reg     <= {ONE_Q, 32'd0};
            shear_reg   <= '0;
            reflect_reg <= '0;
        end
        else
        begin
            origin_reg  <= origin_next;
            shift_reg   <= shift_next;
            scale_reg   <= scale_next;
            rot_reg     <= rot_next;
            shear_reg   <= shear_next;
            reflect_reg <= reflect_next;
        end
    end

    assign cfg.origin_x = origin_reg[63:32];
    assign cfg.origin_y = origin_reg[31:0];
    assign cfg.shift_x  = shift_reg[63:32];
    assign cfg.shift_y  = shift_reg[31:0];
    assign cfg.scale_x  = scale_reg[63:32];
    assign cfg.scale_y  = scale_reg[31:0];
    assign cfg.rot_cos  = rot_reg[63:32];
    assign cfg.rot_sin  = rot_reg[31:0];
    assign cfg.tan_x    = shear_reg[63:32];
    assign cfg.tan_y    = shear_reg[31:0];
    assign cfg.reflect  = reflect_reg;

endmodule

/* rtl/avt_front.sv */
// Front stage: origin subtraction and per-axis reflection, one register stage.
// Depends on avt_pkg for the vertex types and saturation.
module avt_front
    import avt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  avt_in_t            up_data,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic [1:0]         reflect,
    output logic               dn_valid,
    input  logic               dn_ready,
    output avt_vec_t           dn_data
);

    logic        v_reg;
    avt_vec_t    d_reg, d_next;
    logic signed [32:0] dx, dy;
    logic signed [31:0] sx, sy;

    assign up_ready = !v_reg || dn_ready;

    always_comb
    begin
        dx = 33'(up_data.in_x) - 33'(origin_x);
        dy = 33'(up_data.in_y) - 33'(origin_y);
        sx = sat32(66'(dx));
        sy = sat32(66'(dy));
        d_next.x    = reflect[0] ? sat32(-66'(sx)) : sx;
        d_next.y    = reflect[1] ? sat32(-66'(sy)) : sy;
        d_next.last = up_data.in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

/* rtl/avt_mat2.sv */
// 2x2 matrix times vector: product stage then sum-and-saturate stage.
// Depends on avt_pkg; used for both the rotation and the shear.
module avt_mat2
    import avt_pkg::*;
#(
    parameter int FRAC_BITS = AVT_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  avt_vec_t           up_data,
    input  logic signed [32:0] m00,
    input  logic signed [32:0] m01,
    input  logic signed [32:0] m10,
    input  logic signed [32:0] m11,
    output logic               dn_valid,
    input  logic               dn_ready,
    output avt_vec_t           dn_data
);

    logic               va_reg, vb_reg, rdy_b;
    logic signed [64:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [64:0] p00_next, p01_next, p10_next, p11_next;
    logic               last_reg;
    avt_vec_t           d_reg, d_next;

    assign rdy_b    = !vb_reg || dn_ready;
    assign up_ready = !va_reg || rdy_b;

    always_comb
    begin
        p00_next = 65'(m00) * 65'(up_data.x);
        p01_next = 65'(m01) * 65'(up_data.y);
        p10_next = 65'(m10) * 65'(up_data.x);
        p11_next = 65'(m11) * 65'(up_data.y);
    end

    // Arithmetic shift drops the fraction with floor rounding.
    always_comb
    begin
        d_next.x    = sat32(66'(p00_reg >>> FRAC_BITS) + 66'(p01_reg >>> FRAC_BITS));
        d_next.y    = sat32(66'(p10_reg >>> FRAC_BITS) + 66'(p11_reg >>> FRAC_BITS));
        d_next.last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                va_reg <= up_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            last_reg <= up_data.last;
        end
        if (rdy_b && va_reg)
        begin
            d_reg <= d_next;
        end
    end

    assign dn_valid = vb_reg;
    assign dn_data  = d_reg;

endmodule

/* rtl/avt_back.sv */
// Back end: per-axis scale product, then saturate and add shift plus origin.
// Depends on avt_pkg for the vertex types and saturation.
module avt_back
    import avt_pkg::*;
#(
    parameter int FRAC_BITS = AVT_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  avt_vec_t           up_data,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    output logic               dn_valid,
    input  logic               dn_ready,
    output avt_out_t           dn_data
);

    logic               va_reg, vb_reg, rdy_b;
    logic signed [63:0] px_reg, py_reg, px_next, py_next;
    logic               last_reg;
    logic signed [31:0] tx, ty;
    avt_out_t           d_reg, d_next;

    assign rdy_b    = !vb_reg || dn_ready;
    assign up_ready = !va_reg || rdy_b;

    always_comb
    begin
        px_next = 64'(up_data.x) * 64'(scale_x);
        py_next = 64'(up_data.y) * 64'(scale_y);
    end

    always_comb
    begin
        tx = sat32(66'(px_reg >>> FRAC_BITS));
        ty = sat32(66'(py_reg >>> FRAC_BITS));
        d_next.out_x    = sat32(66'(tx) + 66'(shift_x) + 66'(origin_x));
        d_next.out_y    = sat32(66'(ty) + 66'(shift_y) + 66'(origin_y));
        d_next.out_last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                va_reg <= up_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            last_reg <= up_data.last;
        end
        if (rdy_b && va_reg)
        begin
            d_reg <= d_next;
        end
    end

    assign dn_valid = vb_reg;
    assign dn_data  = d_reg;

endmodule

/* rtl/affine_vertex_transform_2d.sv */
// Top level of the 2D affine vertex transform pipeline.
// Depends on avt_pkg, avt_cfg, avt_front, avt_mat2 and avt_back.
//
//   channel   signals                                   word
//   -------   ---------------------------------------   ---------------------------
//   vertex    vtx_valid, vtx_ready, vtx                 avt_in_t  {x, y, last}
//   result    res_valid, res_ready, res                 avt_out_t {x, y, last}
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data 3-bit index, 64-bit value
//
// Throughput is one vertex per cycle while the result is not stalled; the register
// stages, in order, are origin/reflect, rotate products, rotate sums, shear products,
// shear sums, scale products, scale/offset with saturation.
// Reset clears every valid bit and loads the identity transform into the registers.
// A stalled result holds each stage whose successor is full; empty stages keep
// filling, so bubbles close up and no word is dropped or repeated.
// Config writes are always accepted (cfg_ready is tied high); write only while the pipe is empty.
module affine_vertex_transform_2d
    import avt_pkg::*;
#(
    parameter int FRAC_BITS = AVT_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vtx_valid,
    output logic        vtx_ready,
    input  avt_in_t     vtx,
    output logic        res_valid,
    input  logic        res_ready,
    output avt_out_t    res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // 1.0 as a matrix coefficient for the shear diagonal
    localparam logic signed [32:0] ONE_C = 33'sd1 <<< FRAC_BITS;

    avt_cfg_t cfg;

    logic     f_valid, f_ready;
    avt_vec_t f_data;
    logic     r_valid, r_ready;
    avt_vec_t r_data;
    logic     s_valid, s_ready;
    avt_vec_t s_data;

    logic signed [32:0] c_cos, c_sin, c_nsin, c_tx, c_ty;

    assign c_cos  = 33'(cfg.rot_cos);
    assign c_sin  = 33'(cfg.rot_sin);
    assign c_nsin = -33'(cfg.rot_sin);
    assign c_tx   = 33'(cfg.tan_x);
    assign c_ty   = 33'(cfg.tan_y);

    avt_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Subtract the origin, then reflect.
    avt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vtx_valid),
        .up_ready (vtx_ready),
        .up_data  (vtx),
        .origin_x (cfg.origin_x),
        .origin_y (cfg.origin_y),
        .reflect  (cfg.reflect),
        .dn_valid (f_valid),
        .dn_ready (f_ready),
        .dn_data  (f_data)
    );

    // Rotate by [cos sin; -sin cos].
    avt_mat2 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (f_valid),
        .up_ready (f_ready),
        .up_data  (f_data),
        .m00      (c_cos),
        .m01      (c_sin),
        .m10      (c_nsin),
        .m11      (c_cos),
        .dn_valid (r_valid),
        .dn_ready (r_ready),
        .dn_data  (r_data)
    );

    // Shear by [1 tx; ty 1]; the unit diagonal passes the value through exactly.
    avt_mat2 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shear (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (r_valid),
        .up_ready (r_ready),
        .up_data  (r_data),
        .m00      (ONE_C),
        .m01      (c_tx),
        .m10      (c_ty),
        .m11      (ONE_C),
        .dn_valid (s_valid),
        .dn_ready (s_ready),
        .dn_data  (s_data)
    );

    // Scale each axis, then add shift plus origin.
    avt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_data  (s_data),
        .scale_x  (cfg.scale_x),
        .scale_y  (cfg.scale_y),
        .shift_x  (cfg.shift_x),
        .shift_y  (cfg.shift_y),
        .origin_x (cfg.origin_x),
        .origin_y (cfg.origin_y),
        .dn_valid (res_valid),
        .dn_ready (res_ready),
        .dn_data  (res)
    );

endmodule
